### rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types, field widths, operation codes and the bucket hash for the
// address resolution cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int PA_W     = 32;
	localparam int HA_W     = 48;
	localparam int ENTRY_W  = PA_W + HA_W;
	// widest raw hash value is 255 * 400, which fits in 17 bits
	localparam int HASH_W   = 17;
	localparam int HASH_MUL = 7;

	typedef logic [1:0]        op_t;
	typedef logic [PA_W-1:0]   pa_t;
	typedef logic [HA_W-1:0]   ha_t;
	typedef logic [HASH_W-1:0] hash_t;

	localparam op_t OP_LOOKUP = 2'd0;
	localparam op_t OP_UPDATE = 2'd1;
	localparam op_t OP_INSERT = 2'd2;
	localparam op_t OP_FLUSH  = 2'd3;

	// Fold the four octets, first octet most significant, times seven each step
	function automatic hash_t bucket_hash(input pa_t pa);
		hash_t h;
		h = hash_t'(pa[31:24]);
		h = h * hash_t'(HASH_MUL) + hash_t'(pa[23:16]);
		h = h * hash_t'(HASH_MUL) + hash_t'(pa[15:8]);
		h = h * hash_t'(HASH_MUL) + hash_t'(pa[7:0]);
		return h;
	endfunction

endpackage

### rtl/arpc_ram.sv
// ----------------------------------------------------------------------------
// arpc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/arp_cache_hashed_buckets.sv
// ----------------------------------------------------------------------------
// arp_cache_hashed_buckets
// Set-associative address resolution cache with round-robin replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive operation, protocol_address and hardware_address
//   and raise start; the command transfers at a rising edge with start high
//   and busy low. Operations: lookup, update if present, update or insert,
//   flush all.
//   Result channel: done is high for exactly one cycle with hit,
//   found_hardware_address and inserted valid in that cycle. The receiver
//   cannot stall; each result must be taken when shown.
//   Sequence: a lookup, update or insert passes from transfer through the
//   quotient state (reciprocal multiply), the remainder state (correction
//   and bucket read from the RAM) and the compare and write-back state;
//   done rises as the sequencer returns to idle, and a new command may
//   transfer in that same cycle.
//   Flush: the clearing pass writes one bucket row per cycle, then done
//   pulses.
//   Reset: arst_n low forces the same clearing pass (busy high, no done
//   pulse) so the store starts all zero.
// ----------------------------------------------------------------------------
module arp_cache_hashed_buckets #(
	parameter int BUCKETS = 64,
	parameter int WAYS    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  arpc_pkg::op_t        operation,
	input  arpc_pkg::pa_t        protocol_address,
	input  arpc_pkg::ha_t        hardware_address,
	output logic                 done,
	output logic                 hit,
	output arpc_pkg::ha_t        found_hardware_address,
	output logic                 inserted
);

	import arpc_pkg::*;

	localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int PTR_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W = WAYS * ENTRY_W + PTR_W;
	localparam int PROD_W = 2 * HASH_W + 1;

	// reciprocal of the bucket count, scaled by 2^HASH_W (floor)
	localparam logic [HASH_W:0]   RECIP   = (HASH_W + 1)'((2 ** HASH_W) / BUCKETS);
	localparam hash_t             BKT_C   = hash_t'(BUCKETS);
	localparam logic [BKT_W-1:0]  BKT_LAST = BKT_W'(BUCKETS - 1);
	localparam logic [PTR_W-1:0]  WAY_LAST = PTR_W'(WAYS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_QUO  = 3'd1;
	localparam logic [2:0] ST_REM  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_CLR  = 3'd4;

	logic [2:0]       state_q;
	op_t              op_q;
	pa_t              pa_q;
	ha_t              ha_q;
	hash_t            hash_q;
	hash_t            quo_q;
	logic [BKT_W-1:0] bucket_q;
	logic [BKT_W-1:0] clr_cnt_q;
	logic             flush_q;
	logic             done_q;

	logic [PROD_W-1:0] quo_prod;
	hash_t             quo_times_b;
	hash_t             rem_raw;
	hash_t             rem_fix;
	logic [BKT_W-1:0]  bucket_idx;

	logic             ram_we;
	logic [BKT_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic             ram_re;
	logic [ROW_W-1:0] row;

	logic             match_any;
	logic [PTR_W-1:0] match_way;
	logic [PTR_W-1:0] ptr_cur;
	logic [PTR_W-1:0] ptr_next;
	logic [PTR_W-1:0] tgt_way;
	ha_t              match_ha;
	logic             upd_hit_wr;
	logic             upd_ins;
	logic [ROW_W-1:0] row_new;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	// Quotient estimate: at most one below the true quotient
	assign quo_prod = PROD_W'(hash_q) * PROD_W'(RECIP);

	// Remainder from the registered quotient, one correcting subtract
	assign quo_times_b = quo_q * BKT_C;
	assign rem_raw     = hash_q - quo_times_b;
	assign rem_fix     = (rem_raw >= BKT_C) ? (rem_raw - BKT_C) : rem_raw;
	assign bucket_idx  = BKT_W'(rem_fix);

	// Compare all ways of the bucket; the lowest matching way wins
	always_comb begin
		match_any = 1'b0;
		match_way = '0;
		match_ha  = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row[w*ENTRY_W +: PA_W] == pa_q) begin
				match_any = 1'b1;
				match_way = PTR_W'(w);
				match_ha  = row[w*ENTRY_W + PA_W +: HA_W];
			end
		end
	end

	// Advance the round-robin pointer, wrapping at the last way
	assign ptr_cur  = row[WAYS*ENTRY_W +: PTR_W];
	assign ptr_next = (ptr_cur == WAY_LAST) ? '0 : ptr_cur + PTR_W'(1);

	assign upd_hit_wr = match_any && (op_q != OP_LOOKUP);
	assign upd_ins    = !match_any && (op_q == OP_INSERT);
	assign tgt_way    = match_any ? match_way : ptr_next;

	// Build the write-back row
	always_comb begin
		row_new = row;
		for (int w = 0; w < WAYS; w++) begin
			if (PTR_W'(w) == tgt_way) begin
				row_new[w*ENTRY_W + PA_W +: HA_W] = ha_q;
				if (upd_ins) begin
					row_new[w*ENTRY_W +: PA_W] = pa_q;
				end
			end
		end
		if (upd_ins) begin
			row_new[WAYS*ENTRY_W +: PTR_W] = ptr_next;
		end
	end

	// RAM port control: clearing pass or write-back
	always_comb begin
		ram_re    = (state_q == ST_REM);
		ram_we    = 1'b0;
		ram_waddr = bucket_q;
		ram_wdata = row_new;
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			ST_UPD: begin
				ram_we = upd_hit_wr || upd_ins;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	arpc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(BUCKETS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(bucket_idx),
		.rdata(row)
	);

	// Sequencer: reset starts with a clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_cnt_q <= '0;
			flush_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (operation == OP_FLUSH) begin
							state_q   <= ST_CLR;
							clr_cnt_q <= '0;
							flush_q   <= 1'b1;
						end else begin
							state_q <= ST_QUO;
						end
					end
				end
				ST_QUO: begin
					state_q <= ST_REM;
				end
				ST_REM: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + BKT_W'(1);
					if (clr_cnt_q == BKT_LAST) begin
						state_q <= ST_IDLE;
						done_q  <= flush_q;
						flush_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the command and its bucket computation
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q   <= operation;
			pa_q   <= protocol_address;
			ha_q   <= hardware_address;
			hash_q <= bucket_hash(protocol_address);
		end
		if (state_q == ST_QUO) begin
			quo_q <= quo_prod[HASH_W +: HASH_W];
		end
		if (state_q == ST_REM) begin
			bucket_q <= bucket_idx;
		end
	end

	// Result fields; flush reports all zero
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			hit                    <= match_any;
			found_hardware_address <= (match_any && op_q == OP_LOOKUP) ? match_ha : '0;
			inserted               <= upd_ins;
		end else if (state_q == ST_CLR) begin
			hit                    <= 1'b0;
			found_hardware_address <= '0;
			inserted               <= 1'b0;
		end
	end

endmodule
